// ===== rtl/swhsr_pkg.sv =====
// Shared types and constants for the single-wire humidity sensor reader.
// No dependencies; used by every module under rtl/.
package swhsr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PRE       = 3'd1,
        PH_WAKE      = 3'd2,
        PH_REL       = 3'd3,
        PH_ACK_LOW   = 3'd4,
        PH_ACK_HIGH  = 3'd5,
        PH_DATA_LOW  = 3'd6,
        PH_DATA_HIGH = 3'd7
    } t_phase;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_PRE_HIGH = 3'd0;
    localparam logic [2:0] REG_WAKE_LOW = 3'd1;
    localparam logic [2:0] REG_RELEASE  = 3'd2;
    localparam logic [2:0] REG_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_LOW_ADJ  = 3'd4;

    localparam logic [17:0] RST_PRE_HIGH = 18'd250000;
    localparam logic [15:0] RST_WAKE_LOW = 16'd2000;
    localparam logic [9:0]  RST_RELEASE  = 10'd50;
    localparam logic [15:0] RST_TIMEOUT  = 16'd1200;
    localparam logic [7:0]  RST_LOW_ADJ  = 8'd9;

    localparam int unsigned FRAME_BITS = 40;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
    localparam int unsigned DIV10_SHIFT = 19;

    typedef struct packed {
        logic [17:0] pre_high_ticks;
        logic [15:0] wake_low_ticks;
        logic [9:0]  release_ticks;
        logic [15:0] timeout_ticks;
        logic [7:0]  low_adjust;
    } t_cfg;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  read_status;
        logic [15:0] temperature_tenths;
        logic [12:0] humidity_percent;
    } t_result;

endpackage

// ===== rtl/swhsr_cfg.sv =====
// APB-style configuration registers for the sensor reader.
// Depends on swhsr_pkg (t_cfg, register indexes, reset values).
module swhsr_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output swhsr_pkg::t_cfg      o_cfg
);

    swhsr_pkg::t_cfg r_cfg;
    logic [2:0]      reg_idx;
    logic            wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_high_ticks <= swhsr_pkg::RST_PRE_HIGH;
            r_cfg.wake_low_ticks <= swhsr_pkg::RST_WAKE_LOW;
            r_cfg.release_ticks  <= swhsr_pkg::RST_RELEASE;
            r_cfg.timeout_ticks  <= swhsr_pkg::RST_TIMEOUT;
            r_cfg.low_adjust     <= swhsr_pkg::RST_LOW_ADJ;
        end else if (wr_en) begin
            unique case (reg_idx)
                swhsr_pkg::REG_PRE_HIGH: r_cfg.pre_high_ticks <= pwdata[17:0];
                swhsr_pkg::REG_WAKE_LOW: r_cfg.wake_low_ticks <= pwdata[15:0];
                swhsr_pkg::REG_RELEASE:  r_cfg.release_ticks  <= pwdata[9:0];
                swhsr_pkg::REG_TIMEOUT:  r_cfg.timeout_ticks  <= pwdata[15:0];
                swhsr_pkg::REG_LOW_ADJ:  r_cfg.low_adjust     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            swhsr_pkg::REG_PRE_HIGH: prdata = {14'd0, r_cfg.pre_high_ticks};
            swhsr_pkg::REG_WAKE_LOW: prdata = {16'd0, r_cfg.wake_low_ticks};
            swhsr_pkg::REG_RELEASE:  prdata = {22'd0, r_cfg.release_ticks};
            swhsr_pkg::REG_TIMEOUT:  prdata = {16'd0, r_cfg.timeout_ticks};
            swhsr_pkg::REG_LOW_ADJ:  prdata = {24'd0, r_cfg.low_adjust};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/swhsr_decode.sv =====
// Frame decode: checksum check, sign-magnitude temperature, humidity / 10.
// Depends on swhsr_pkg (divide-by-ten reciprocal).
module swhsr_decode (
    input  logic [39:0] i_frame,
    output logic        o_sum_ok,
    output logic [15:0] o_temperature,
    output logic [12:0] o_humidity
);

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  sum;
    logic [15:0] mag;
    logic [31:0] hum_prod;

    assign b0 = i_frame[39:32];
    assign b1 = i_frame[31:24];
    assign b2 = i_frame[23:16];
    assign b3 = i_frame[15:8];
    assign b4 = i_frame[7:0];

    // 8-bit sum wraps, as the sensor's checksum does
    assign sum      = b0 + b1 + b2 + b3;
    assign o_sum_ok = (sum == b4);

    assign mag           = {1'b0, b2[6:0], b3};
    assign o_temperature = b2[7] ? 16'(~mag + 16'd1) : mag;

    assign hum_prod   = {16'd0, b0, b1} * {16'd0, swhsr_pkg::DIV10_RECIP};
    assign o_humidity = hum_prod[swhsr_pkg::DIV10_SHIFT +: 13];

endmodule

// ===== rtl/swhsr_engine.sv =====
// Read sequencer: wake sequence, pulse timing, bit capture and result holds.
// Depends on swhsr_pkg and swhsr_decode.
module swhsr_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_start_req,
    input  logic                 i_line_level,
    input  swhsr_pkg::t_cfg      i_cfg,
    output swhsr_pkg::t_result   o_result
);

    swhsr_pkg::t_phase r_phase, n_phase;
    logic [17:0] r_ticks, n_ticks;
    logic [15:0] r_saved, n_saved;
    logic [5:0]  r_bit, n_bit;
    logic [39:0] r_frame, n_frame;
    logic [15:0] r_temp, n_temp;
    logic [12:0] r_hum, n_hum;
    logic [1:0]  r_status, n_status;

    logic        timed;
    logic        finish;
    logic        want;
    logic [1:0]  end_status;
    logic [15:0] low_cnt;
    logic        data_bit;
    logic [39:0] shifted;
    logic        sum_ok;
    logic [15:0] dec_temp;
    logic [12:0] dec_hum;

    // first bit of bytes one to four gets the low-count adjustment
    always_comb begin
        low_cnt = r_saved;
        if (r_bit[2:0] == 3'd0 && r_bit != 6'd0) begin
            low_cnt = (r_saved > {8'd0, i_cfg.low_adjust})
                    ? r_saved - {8'd0, i_cfg.low_adjust} : 16'd0;
        end
    end

    assign data_bit = r_ticks > {2'd0, low_cnt};
    assign shifted  = {r_frame[38:0], data_bit};

    swhsr_decode u_decode (
        .i_frame       (shifted),
        .o_sum_ok      (sum_ok),
        .o_temperature (dec_temp),
        .o_humidity    (dec_hum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= swhsr_pkg::PH_IDLE;
            r_ticks  <= '0;
            r_saved  <= '0;
            r_bit    <= '0;
            r_frame  <= '0;
            r_temp   <= '0;
            r_hum    <= '0;
            r_status <= swhsr_pkg::ST_OK;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_ticks  <= n_ticks;
            r_saved  <= n_saved;
            r_bit    <= n_bit;
            r_frame  <= n_frame;
            r_temp   <= n_temp;
            r_hum    <= n_hum;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_ticks    = r_ticks;
        n_saved    = r_saved;
        n_bit      = r_bit;
        n_frame    = r_frame;
        n_temp     = r_temp;
        n_hum      = r_hum;
        n_status   = r_status;
        timed      = 1'b0;
        finish     = 1'b0;
        want       = 1'b0;
        end_status = swhsr_pkg::ST_TIMEOUT;
        o_result   = '0;

        if (r_phase == swhsr_pkg::PH_IDLE && i_start_req) begin
            n_phase = swhsr_pkg::PH_PRE;
            n_ticks = '0;
            n_bit   = '0;
            n_frame = '0;
            n_saved = '0;
        end

        // wake sequence; a zero-length phase falls through in the same tick
        if (n_phase == swhsr_pkg::PH_PRE) begin
            if (n_ticks < i_cfg.pre_high_ticks) begin
                timed = 1'b1;
            end else begin
                n_phase = swhsr_pkg::PH_WAKE;
                n_ticks = '0;
            end
        end
        if (!timed && n_phase == swhsr_pkg::PH_WAKE) begin
            if (n_ticks < {2'd0, i_cfg.wake_low_ticks}) begin
                timed = 1'b1;
            end else begin
                n_phase = swhsr_pkg::PH_REL;
                n_ticks = '0;
            end
        end
        if (!timed && n_phase == swhsr_pkg::PH_REL) begin
            if (n_ticks < {8'd0, i_cfg.release_ticks}) begin
                timed = 1'b1;
            end else begin
                n_phase = swhsr_pkg::PH_ACK_LOW;
                n_ticks = '0;
            end
        end

        if (timed) begin
            o_result.drive_low = (n_phase == swhsr_pkg::PH_WAKE);
            n_ticks            = n_ticks + 18'd1;
        end else if (n_phase == swhsr_pkg::PH_ACK_LOW || n_phase == swhsr_pkg::PH_ACK_HIGH
                  || n_phase == swhsr_pkg::PH_DATA_LOW
                  || n_phase == swhsr_pkg::PH_DATA_HIGH) begin
            want = (n_phase == swhsr_pkg::PH_ACK_HIGH || n_phase == swhsr_pkg::PH_DATA_HIGH);
            if (i_line_level == want) begin
                n_ticks = n_ticks + 18'd1;
            end else if (n_ticks == 18'd0) begin
                finish = 1'b1;
            end else begin
                unique case (n_phase)
                    swhsr_pkg::PH_DATA_LOW: begin
                        n_saved = n_ticks[15:0];
                        n_phase = swhsr_pkg::PH_DATA_HIGH;
                    end
                    swhsr_pkg::PH_DATA_HIGH: begin
                        n_frame = shifted;
                        n_bit   = r_bit + 6'd1;
                        if (n_bit == 6'(swhsr_pkg::FRAME_BITS)) begin
                            finish = 1'b1;
                            if (sum_ok) begin
                                end_status = swhsr_pkg::ST_OK;
                                n_temp     = dec_temp;
                                n_hum      = dec_hum;
                            end else begin
                                end_status = swhsr_pkg::ST_CHECKSUM;
                            end
                        end else begin
                            n_phase = swhsr_pkg::PH_DATA_LOW;
                        end
                    end
                    swhsr_pkg::PH_ACK_LOW:  n_phase = swhsr_pkg::PH_ACK_HIGH;
                    swhsr_pkg::PH_ACK_HIGH: n_phase = swhsr_pkg::PH_DATA_LOW;
                    default: ;
                endcase
                n_ticks = 18'd1;
            end
            if (!finish && n_ticks > {2'd0, i_cfg.timeout_ticks}) begin
                finish = 1'b1;
            end
            if (finish) begin
                n_phase           = swhsr_pkg::PH_IDLE;
                n_ticks           = '0;
                n_status          = end_status;
                o_result.done_res = 1'b1;
            end
        end

        o_result.busy_res           = (n_phase != swhsr_pkg::PH_IDLE);
        o_result.read_status        = n_status;
        o_result.temperature_tenths = n_temp;
        o_result.humidity_percent   = n_hum;
    end

endmodule

// ===== rtl/single_wire_humidity_sensor_reader_top.sv =====
// Single-wire temperature/humidity sensor reader, top level.
// Depends on swhsr_pkg, swhsr_cfg, swhsr_engine (which holds swhsr_decode).
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one transaction per sample tick,
//    carrying the start request and the sampled data line level.
//  - Output channel (o_out_valid / i_out_ready): exactly one result
//    transaction per input transaction, in order: line drive, busy, done,
//    status, and the temperature / humidity of the last good read.
//  - Latency: the result of a tick is offered the cycle after its input
//    transaction is taken. Throughput: one tick per cycle while the receiver
//    keeps taking results.
//  - The result register is the only buffer; the input is taken whenever the
//    register is empty or is being emptied in the same cycle. When the
//    receiver stalls, the result holds and o_in_ready drops until it goes.
//  - Reset (i_rst_n low, synchronous): sequencer idle, holds cleared, status
//    ok, registers at their defaults, no result pending.
//  - Configuration via the APB-style port at byte address 4 * index; write
//    only while no read is in flight and no result is pending.
//  - o_drive_low is meant for an open-drain pad: 1 pulls the line low.
module single_wire_humidity_sensor_reader_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_start_req,
    input  logic        i_line_level,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_drive_low,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [1:0]  o_read_status,
    output logic [15:0] o_temperature_tenths,
    output logic [12:0] o_humidity_percent,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    swhsr_pkg::t_cfg    cfg;
    swhsr_pkg::t_result step_res;
    swhsr_pkg::t_result r_out;
    logic               r_out_valid;
    logic               in_accept;

    // take a tick when the result register is free or drains this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    swhsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer state advances only on accepted ticks
    swhsr_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_start_req  (i_start_req),
        .i_line_level (i_line_level),
        .i_cfg        (cfg),
        .o_result     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_drive_low          = r_out.drive_low;
    assign o_busy_res           = r_out.busy_res;
    assign o_done_res           = r_out.done_res;
    assign o_read_status        = r_out.read_status;
    assign o_temperature_tenths = r_out.temperature_tenths;
    assign o_humidity_percent   = r_out.humidity_percent;

endmodule

// ===== test/single_wire_humidity_sensor_reader_top_tb.sv =====
// Self-checking testbench for single_wire_humidity_sensor_reader_top: sample ticks in,
// one result transaction per tick out, checked against a tick-level predictor.
// Depends on swhsr_pkg and the RTL under rtl/.
module single_wire_humidity_sensor_reader_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // quiet cycles (no transaction on either channel) before the run is declared hung
    localparam int WATCHDOG_LIMIT  = 4000;
    // long receiver hold-off used to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 400;
    // result lands the cycle after its tick is taken; a little margin on top
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 10;

    typedef struct packed {
        logic start;
        logic line;
    } t_tick;

    typedef enum int {
        FRAME_GOOD,      // well-formed read, checksum right
        FRAME_BAD_SUM,   // well-formed read, checksum byte corrupted
        FRAME_NO_ACK,    // line already high when the ack low is timed
        FRAME_OVERLONG   // one pulse runs past the timeout
    } t_frame_kind;

    // ---------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic        i_start_req  = 1'b0;
    logic        i_line_level = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic        o_drive_low;
    logic        o_busy_res;
    logic        o_done_res;
    logic [1:0]  o_read_status;
    logic [15:0] o_temperature_tenths;
    logic [12:0] o_humidity_percent;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [4:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    single_wire_humidity_sensor_reader_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Stimulus queue, expected results, traffic knobs
    // ---------------------------------------------------------------
    t_tick              tick_queue[$];
    swhsr_pkg::t_result expected_results[$];
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 hold_requests  = 0;
    int                 holds_taken    = 0;
    int                 hold_left      = 0;
    int                 fail_count     = 0;
    int                 quiet_cycles   = 0;
    int                 ticks_queued   = 0;
    logic               stray_starts   = 1'b0;   // sprinkle start requests into busy ticks
    t_tick              next_tick;
    swhsr_pkg::t_result predicted;
    swhsr_pkg::t_result oldest;

    // ---------------------------------------------------------------
    // Predictor state: configuration copy plus the sequencer registers.
    // Starts at reset values; reset is applied once at time zero.
    // ---------------------------------------------------------------
    swhsr_pkg::t_cfg   model_cfg     = {swhsr_pkg::RST_PRE_HIGH, swhsr_pkg::RST_WAKE_LOW,
                                        swhsr_pkg::RST_RELEASE, swhsr_pkg::RST_TIMEOUT,
                                        swhsr_pkg::RST_LOW_ADJ};
    swhsr_pkg::t_phase sim_phase     = swhsr_pkg::PH_IDLE;
    logic [17:0]       sim_ticks     = '0;
    logic [15:0]       sim_low_saved = '0;
    logic [5:0]        sim_bit_num   = '0;
    logic [39:0]       sim_frame     = '0;
    logic [15:0]       sim_temp      = '0;
    logic [12:0]       sim_hum       = '0;
    logic [1:0]        sim_status    = swhsr_pkg::ST_OK;

    // One sample tick through the sensor sequencer; returns the tick's result.
    task automatic sensor_predict(input logic start, input logic line,
                                  output swhsr_pkg::t_result res);
        logic [17:0] dur;
        logic        timed;
        logic        closing;
        logic        want;
        logic [1:0]  status;
        logic [15:0] low;
        logic [7:0]  b0, b1, b2, b3, b4, chk;
        logic [14:0] mag;
        res     = '0;
        timed   = 1'b0;
        closing = 1'b0;
        status  = swhsr_pkg::ST_TIMEOUT;

        if (sim_phase == swhsr_pkg::PH_IDLE && start) begin
            sim_phase     = swhsr_pkg::PH_PRE;
            sim_ticks     = '0;
            sim_bit_num   = '0;
            sim_frame     = '0;
            sim_low_saved = '0;
        end

        // wake sequence: zero-length steps fall through within the same tick
        while (!timed && (sim_phase == swhsr_pkg::PH_PRE || sim_phase == swhsr_pkg::PH_WAKE
                          || sim_phase == swhsr_pkg::PH_REL)) begin
            if (sim_phase == swhsr_pkg::PH_PRE)
                dur = model_cfg.pre_high_ticks;
            else if (sim_phase == swhsr_pkg::PH_WAKE)
                dur = 18'(model_cfg.wake_low_ticks);
            else
                dur = 18'(model_cfg.release_ticks);
            if (sim_ticks < dur) begin
                res.drive_low = (sim_phase == swhsr_pkg::PH_WAKE);
                sim_ticks     = sim_ticks + 18'd1;
                timed         = 1'b1;
            end else begin
                sim_phase = swhsr_pkg::t_phase'(sim_phase + 3'd1);
                sim_ticks = '0;
            end
        end

        // pulse timing: ack low, ack high, then 40 low/high pairs
        if (!timed && sim_phase >= swhsr_pkg::PH_ACK_LOW) begin
            want = (sim_phase == swhsr_pkg::PH_ACK_HIGH ||
                    sim_phase == swhsr_pkg::PH_DATA_HIGH);
            if (line == want) begin
                sim_ticks = sim_ticks + 18'd1;
            end else if (sim_ticks == '0) begin
                closing = 1'b1;     // zero-length pulse
            end else begin
                if (sim_phase == swhsr_pkg::PH_DATA_LOW) begin
                    sim_low_saved = sim_ticks[15:0];
                    sim_phase     = swhsr_pkg::PH_DATA_HIGH;
                end else if (sim_phase == swhsr_pkg::PH_DATA_HIGH) begin
                    low = sim_low_saved;
                    // first bit of bytes 1..4: saturating low-count trim
                    if (sim_bit_num == 6'd8 || sim_bit_num == 6'd16 ||
                        sim_bit_num == 6'd24 || sim_bit_num == 6'd32)
                        low = (low > 16'(model_cfg.low_adjust)) ?
                              low - 16'(model_cfg.low_adjust) : '0;
                    sim_frame   = {sim_frame[38:0], (sim_ticks > 18'(low))};
                    sim_bit_num = sim_bit_num + 6'd1;
                    if (sim_bit_num >= swhsr_pkg::FRAME_BITS) begin
                        b0  = sim_frame[39:32];
                        b1  = sim_frame[31:24];
                        b2  = sim_frame[23:16];
                        b3  = sim_frame[15:8];
                        b4  = sim_frame[7:0];
                        chk = b0 + b1 + b2 + b3;
                        if (b4 != chk) begin
                            status = swhsr_pkg::ST_CHECKSUM;   // holds keep old values
                        end else begin
                            mag      = {b2[6:0], b3};
                            sim_temp = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
                            sim_hum  = 13'({b0, b1} / 16'd10);
                            status   = swhsr_pkg::ST_OK;
                        end
                        closing = 1'b1;
                    end else begin
                        sim_phase = swhsr_pkg::PH_DATA_LOW;
                    end
                end else begin
                    sim_phase = swhsr_pkg::t_phase'(sim_phase + 3'd1);
                end
                sim_ticks = 18'd1;  // the edge tick opens the next pulse
            end
            if (!closing && sim_ticks > 18'(model_cfg.timeout_ticks))
                closing = 1'b1;
            if (closing) begin
                sim_phase     = swhsr_pkg::PH_IDLE;
                sim_ticks     = '0;
                sim_status    = status;
                res.done_res  = 1'b1;
            end
        end

        res.busy_res           = (sim_phase != swhsr_pkg::PH_IDLE);
        res.read_status        = sim_status;
        res.temperature_tenths = sim_temp;
        res.humidity_percent   = sim_hum;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // Input driver: offers the next queued tick, with random sender gaps.
    // Payload only changes when the channel is empty or just accepted.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_tick    = tick_queue.pop_front();
                i_in_valid   <= 1'b1;
                i_start_req  <= next_tick.start;
                i_line_level <= next_tick.line;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (holds_taken != hold_requests) begin
            holds_taken <= holds_taken + 1;
            hold_left   <= HOLD_OFF_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on every accepted tick, compare every accepted result
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sensor_predict(i_start_req, i_line_level, predicted);
                expected_results.push_back(predicted);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("drive_low", oldest.drive_low, o_drive_low);
                    check_field("busy_res", oldest.busy_res, o_busy_res);
                    check_field("done_res", oldest.done_res, o_done_res);
                    check_field("read_status", oldest.read_status, o_read_status);
                    check_field("temperature_tenths", $signed(oldest.temperature_tenths),
                                $signed(o_temperature_tenths));
                    check_field("humidity_percent", oldest.humidity_percent,
                                o_humidity_percent);
                end
            end
        end
    end

    // Watchdog: too long with no transaction on either channel means a hang
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Configuration port: read checks against the model copy
    // ---------------------------------------------------------------
    task automatic cfg_read_check(input logic [2:0] idx);
        logic [31:0] want;
        case (idx)
            swhsr_pkg::REG_PRE_HIGH: want = 32'(model_cfg.pre_high_ticks);
            swhsr_pkg::REG_WAKE_LOW: want = 32'(model_cfg.wake_low_ticks);
            swhsr_pkg::REG_RELEASE:  want = 32'(model_cfg.release_ticks);
            swhsr_pkg::REG_TIMEOUT:  want = 32'(model_cfg.timeout_ticks);
            swhsr_pkg::REG_LOW_ADJ:  want = 32'(model_cfg.low_adjust);
            default:                 want = '0;
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("prdata", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);   // register takes the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            swhsr_pkg::REG_PRE_HIGH: model_cfg.pre_high_ticks = value[17:0];
            swhsr_pkg::REG_WAKE_LOW: model_cfg.wake_low_ticks = value[15:0];
            swhsr_pkg::REG_RELEASE:  model_cfg.release_ticks  = value[9:0];
            swhsr_pkg::REG_TIMEOUT:  model_cfg.timeout_ticks  = value[15:0];
            swhsr_pkg::REG_LOW_ADJ:  model_cfg.low_adjust     = value[7:0];
            default: ;
        endcase
        cfg_read_check(idx);
    endtask

    task automatic load_config(input int pre, input int wake, input int rel, input int tmo,
                               input int adj);
        cfg_write(swhsr_pkg::REG_PRE_HIGH, 32'(pre));
        cfg_write(swhsr_pkg::REG_WAKE_LOW, 32'(wake));
        cfg_write(swhsr_pkg::REG_RELEASE, 32'(rel));
        cfg_write(swhsr_pkg::REG_TIMEOUT, 32'(tmo));
        cfg_write(swhsr_pkg::REG_LOW_ADJ, 32'(adj));
    endtask

    // ---------------------------------------------------------------
    // Tick generators
    // ---------------------------------------------------------------
    task automatic push_tick(input logic start, input logic line);
        tick_queue.push_back('{start: start, line: line});
        ticks_queued++;
    endtask

    // n ticks at one level; busy ticks may carry a start that must be ignored
    task automatic push_level(input logic level, input int n, input logic allow_stray);
        for (int k = 0; k < n; k++)
            push_tick(allow_stray && stray_starts && ($urandom_range(7) == 0), level);
    endtask

    function automatic int clamp_to_timeout(input int v);
        return (v > int'(model_cfg.timeout_ticks)) ? int'(model_cfg.timeout_ticks) : v;
    endfunction

    function automatic int wake_ticks();
        return int'(model_cfg.pre_high_ticks) + int'(model_cfg.wake_low_ticks) +
               int'(model_cfg.release_ticks);
    endfunction

    // One read: start, wake sequence filler, ack pulses, 40 data bits, closing edge.
    // Body is bytes 0..3; byte 4 is the checksum (corrupted for FRAME_BAD_SUM).
    task automatic push_read(input logic [31:0] body, input t_frame_kind kind);
        logic [39:0] frame_word;
        logic [7:0]  sum;
        logic        level;
        logic        bit_val;
        logic        adjusted;
        int          cut, len, lo, hi, eff, bit_idx, adj;
        adj = int'(model_cfg.low_adjust);
        sum = body[31:24] + body[23:16] + body[15:8] + body[7:0];
        if (kind == FRAME_BAD_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        frame_word = {body, sum};
        cut = (kind == FRAME_OVERLONG) ? $urandom_range(0, 81) : -1;
        hi  = 1;

        push_tick(1'b1, 1'($urandom_range(1)));
        for (int k = 1; k < wake_ticks(); k++)
            push_tick(stray_starts && ($urandom_range(7) == 0), 1'($urandom_range(1)));

        if (kind == FRAME_NO_ACK) begin
            push_tick(1'b0, 1'b1);
            return;
        end

        // pulse 0/1 are the acks; pulse 2+2i / 3+2i carry data bit i
        for (int p = 0; p < 82; p++) begin
            level = p[0];
            if (p < 2) begin
                len = clamp_to_timeout($urandom_range(1, 4));
            end else if (!level) begin
                bit_idx  = (p - 2) / 2;
                bit_val  = frame_word[39 - bit_idx];
                adjusted = (bit_idx == 8 || bit_idx == 16 || bit_idx == 24 || bit_idx == 32);
                if (adjusted && !bit_val)
                    lo = adj + $urandom_range(1, 2);
                else if ($urandom_range(9) == 0)
                    lo = $urandom_range(1, 8);
                else
                    lo = $urandom_range(1, 2);
                lo  = clamp_to_timeout(lo);
                eff = adjusted ? ((lo > adj) ? lo - adj : 0) : lo;
                if (bit_val)
                    hi = eff + $urandom_range(1, 2);
                else
                    hi = $urandom_range(1, (eff > 1) ? eff : 1);
                hi  = clamp_to_timeout(hi);
                len = lo;
            end else begin
                len = hi;
            end
            if (p == cut) begin
                push_level(level, int'(model_cfg.timeout_ticks) + $urandom_range(1, 3), 1'b0);
                return;
            end
            push_level(level, len, 1'b1);
        end
        push_tick(1'b0, 1'b0);     // falling edge closes the last bit
    endtask

    // Random line chatter with occasional starts, then a flush long enough
    // for any read it kicked off to end by timeout.
    task automatic push_noise();
        repeat ($urandom_range(20, 40))
            push_tick($urandom_range(5) == 0, 1'($urandom_range(1)));
        push_level(1'b0, wake_ticks() + int'(model_cfg.timeout_ticks) + 3, 1'b0);
    endtask

    task automatic run_random(input int target);
        int first;
        int pick;
        first = ticks_queued;
        while (ticks_queued - first < target) begin
            pick = $urandom_range(99);
            if (pick < 8)
                push_noise();
            else if (pick < 16)
                push_read($urandom(), FRAME_OVERLONG);
            else if (pick < 22)
                push_read($urandom(), FRAME_NO_ACK);
            else if (pick < 30)
                push_read($urandom(), FRAME_BAD_SUM);
            else
                push_read($urandom(), FRAME_GOOD);
            // idle ticks between reads, ignored by the block
            repeat ($urandom_range(0, 3))
                push_tick(1'b0, 1'($urandom_range(1)));
        end
    endtask

    // Wait for every tick to be taken and checked, then make sure the
    // sequencer is idle; feed a low line until any read left over times out.
    task automatic wait_quiet();
        forever begin
            while (!(tick_queue.size() == 0 && !i_in_valid && expected_results.size() == 0))
                @(negedge i_clk);
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            if (sim_phase == swhsr_pkg::PH_IDLE)
                return;
            push_level(1'b0, 16, 1'b0);
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults, then idle ticks: outputs must show reset holds
        cfg_read_check(swhsr_pkg::REG_PRE_HIGH);
        cfg_read_check(swhsr_pkg::REG_WAKE_LOW);
        cfg_read_check(swhsr_pkg::REG_RELEASE);
        cfg_read_check(swhsr_pkg::REG_TIMEOUT);
        cfg_read_check(swhsr_pkg::REG_LOW_ADJ);
        push_level(1'b1, 3, 1'b0);
        push_level(1'b0, 3, 1'b0);
        wait_quiet();

        // directed reads, no idling
        load_config(2, 3, 1, 20, 9);
        stray_starts = 1'b1;
        push_read({8'hFF, 8'hFF, 8'h7F, 8'hFF}, FRAME_GOOD);    // top humidity, top temp
        push_read({8'h00, 8'h00, 8'h80, 8'h00}, FRAME_GOOD);    // negative zero
        push_read($urandom(), FRAME_BAD_SUM);                   // holds must not move
        push_read($urandom(), FRAME_NO_ACK);
        push_read($urandom(), FRAME_OVERLONG);
        wait_quiet();

        // register maximums read back, then minimum timing; sender idles
        load_config(262143, 65535, 1023, 65535, 255);
        load_config(0, 1, 0, 1, 0);
        send_idle_pct = 84;
        run_random(100);
        wait_quiet();

        // widest timeout; receiver stalls
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        stray_starts   = 1'b0;
        load_config(3, 2, 17, 65535, 12);
        push_read($urandom(), FRAME_GOOD);
        wait_quiet();

        // both sides idle; a long receiver hold-off backs the block up
        stray_starts   = 1'b1;
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        load_config($urandom_range(0, 3), $urandom_range(1, 4), $urandom_range(0, 3),
                    $urandom_range(8, 40), $urandom_range(0, 6));
        run_random(80);
        hold_requests++;
        wait_quiet();

        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
